/* rtl/spsc_pkg.sv */
package spsc_pkg;

	// item kinds
	localparam logic [1:0] OP_PULSE  = 2'd0;
	localparam logic [1:0] OP_UPDATE = 2'd1;
	localparam logic [1:0] OP_LOAD   = 2'd2;

	// period profiles
	localparam logic [1:0] PROF_FAST = 2'd0;
	localparam logic [1:0] PROF_SLOW = 2'd1;
	localparam logic [1:0] PROF_NONE = 2'd2;

	localparam logic [11:0] PERIOD_FAST = 12'd2000;
	localparam logic [11:0] PERIOD_SLOW = 12'd3500;

	// register map, byte address = 4 * index
	localparam int APB_AW = 5;
	localparam logic [2:0] REG_CORR_EN  = 3'd0;
	localparam logic [2:0] REG_ENC_TOL  = 3'd1;
	localparam logic [2:0] REG_DEADBAND = 3'd2;
	localparam logic [2:0] REG_INVERT   = 3'd3;
	localparam logic [2:0] REG_SPR      = 3'd4;
	localparam logic [2:0] REG_PROF_EN  = 3'd5;
	localparam logic [2:0] REG_INNER    = 3'd6;
	localparam logic [2:0] REG_OUTER    = 3'd7;

	localparam logic [15:0] ENC_TOL_RST = 16'd1000;
	localparam logic [31:0] SPR_RST     = 32'd65536;

	typedef struct packed {
		logic        encoder_correction_enable;
		logic [15:0] encoder_tolerance_ms;
		logic [15:0] deadband_steps;
		logic        invert_direction;
		logic [31:0] steps_per_radian;
		logic        profile_enable;
		logic [30:0] inner_limit_steps;
		logic [30:0] outer_limit_steps;
	} spsc_cfg_t;

	typedef struct packed {
		logic [1:0]         opcode;
		logic signed [31:0] position_value;
		logic signed [31:0] target_position;
		logic signed [31:0] encoder_angle;
		logic [15:0]        encoder_age_ms;
		logic               drv_fault;
	} spsc_in_t;

	typedef struct packed {
		logic signed [31:0] position_now;
		logic               running;
		logic               direction_level;
		logic               moving_down;
		logic               arrived;
		logic               fault_seen;
		logic [11:0]        period_ticks;
		logic [1:0]         profile_now;
	} spsc_out_t;

	// item after encoder conversion
	typedef struct packed {
		logic [1:0]  opcode;
		logic [31:0] position_value;
		logic [31:0] target_position;
		logic        drv_fault;
		logic        use_enc;
		logic [31:0] enc_steps;
	} spsc_s2_t;

endpackage

/* rtl/spsc_ifs.sv */
interface spsc_in_if import spsc_pkg::*; ();
	logic     valid;
	logic     ready;
	spsc_in_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface spsc_out_if import spsc_pkg::*; ();
	logic      valid;
	logic      ready;
	spsc_out_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/spsc_apb_regs.sv */
module spsc_apb_regs import spsc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output spsc_cfg_t         cfg
);

	spsc_cfg_t  cfg_q;
	logic       wr_en;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[4:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.encoder_correction_enable <= 1'b0;
			cfg_q.encoder_tolerance_ms      <= ENC_TOL_RST;
			cfg_q.deadband_steps            <= '0;
			cfg_q.invert_direction          <= 1'b0;
			cfg_q.steps_per_radian          <= SPR_RST;
			cfg_q.profile_enable            <= 1'b0;
			cfg_q.inner_limit_steps         <= '0;
			cfg_q.outer_limit_steps         <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_CORR_EN:  cfg_q.encoder_correction_enable <= pwdata[0];
				REG_ENC_TOL:  cfg_q.encoder_tolerance_ms      <= pwdata[15:0];
				REG_DEADBAND: cfg_q.deadband_steps            <= pwdata[15:0];
				REG_INVERT:   cfg_q.invert_direction          <= pwdata[0];
				REG_SPR:      cfg_q.steps_per_radian          <= pwdata;
				REG_PROF_EN:  cfg_q.profile_enable            <= pwdata[0];
				REG_INNER:    cfg_q.inner_limit_steps         <= pwdata[30:0];
				REG_OUTER:    cfg_q.outer_limit_steps         <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_CORR_EN:  prdata = {31'd0, cfg_q.encoder_correction_enable};
			REG_ENC_TOL:  prdata = {16'd0, cfg_q.encoder_tolerance_ms};
			REG_DEADBAND: prdata = {16'd0, cfg_q.deadband_steps};
			REG_INVERT:   prdata = {31'd0, cfg_q.invert_direction};
			REG_SPR:      prdata = cfg_q.steps_per_radian;
			REG_PROF_EN:  prdata = {31'd0, cfg_q.profile_enable};
			REG_INNER:    prdata = {1'b0, cfg_q.inner_limit_steps};
			REG_OUTER:    prdata = {1'b0, cfg_q.outer_limit_steps};
			default:      prdata = '0;
		endcase
	end

endmodule

/* rtl/spsc_enc_stage.sv */
module spsc_enc_stage import spsc_pkg::*; (
	input  logic      clk,
	input  logic      load_s1,
	input  logic      load_s2,
	input  spsc_in_t  in_data,
	input  spsc_cfg_t cfg,
	output spsc_s2_t  item_s2
);

	spsc_in_t    in_s1;
	spsc_s2_t    item_d;
	logic        neg;
	logic [31:0] mag;
	logic [63:0] prod;
	logic [31:0] whole;
	logic [31:0] steps;

	always_ff @(posedge clk) begin
		if (load_s1) begin
			in_s1 <= in_data;
		end
	end

	// sign-magnitude multiply; the most negative angle keeps magnitude 2^31
	assign neg   = in_s1.encoder_angle[31];
	assign mag   = neg ? (32'd0 - in_s1.encoder_angle) : in_s1.encoder_angle;
	assign prod  = {32'd0, mag} * {32'd0, cfg.steps_per_radian};
	assign whole = prod[63:32];

	always_comb begin
		if (neg) begin
			steps = whole[31] ? 32'h8000_0000 : (32'd0 - whole);
		end else begin
			steps = whole[31] ? 32'h7FFF_FFFF : whole;
		end
	end

	always_comb begin
		item_d.opcode          = in_s1.opcode;
		item_d.position_value  = in_s1.position_value;
		item_d.target_position = in_s1.target_position;
		item_d.drv_fault       = in_s1.drv_fault;
		item_d.use_enc         = cfg.encoder_correction_enable &&
		                         (in_s1.encoder_age_ms <= cfg.encoder_tolerance_ms);
		item_d.enc_steps       = steps;
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			item_s2 <= item_d;
		end
	end

endmodule

/* rtl/spsc_core.sv */
module spsc_core import spsc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load_out,
	input  spsc_s2_t  item_s2,
	input  spsc_cfg_t cfg,
	output spsc_out_t res_q
);

	logic [31:0] pos_q, sp_q;
	logic        dir_q, run_q, fault_q;
	logic [1:0]  prof_q;
	logic [11:0] per_q;

	logic [31:0] pos_pulse, pos_mid, mid_mag;
	logic [31:0] pos_f, sp_f;
	logic        dir_f, run_f, fault_f;
	logic [1:0]  prof_f;
	logic [11:0] per_f;
	logic [32:0] diff, diff_mag;
	logic        at_f;

	assign pos_pulse = dir_q ? (pos_q - 32'd1) : (pos_q + 32'd1);
	assign pos_mid   = item_s2.use_enc ? item_s2.enc_steps : pos_q;
	assign mid_mag   = pos_mid[31] ? (32'd0 - pos_mid) : pos_mid;

	always_comb begin
		pos_f   = pos_q;
		sp_f    = sp_q;
		fault_f = fault_q;
		prof_f  = prof_q;
		per_f   = per_q;
		case (item_s2.opcode)
			OP_PULSE: begin
				pos_f = pos_pulse;
			end
			OP_UPDATE: begin
				pos_f   = pos_mid;
				sp_f    = item_s2.target_position;
				fault_f = item_s2.drv_fault;
				if (cfg.profile_enable) begin
					// hysteresis: only a change of profile is acted on
					if ((mid_mag < {1'b0, cfg.inner_limit_steps}) && (prof_q != PROF_FAST)) begin
						prof_f = PROF_FAST;
						per_f  = PERIOD_FAST;
					end else if ((mid_mag > {1'b0, cfg.outer_limit_steps}) &&
					             (prof_q != PROF_SLOW)) begin
						prof_f = PROF_SLOW;
						per_f  = PERIOD_SLOW;
					end
				end
			end
			OP_LOAD: begin
				pos_f   = item_s2.position_value;
				sp_f    = item_s2.position_value;
				fault_f = 1'b0;
			end
			default: ;
		endcase
	end

	// exact distance to setpoint in 33 bits
	assign diff     = {pos_f[31], pos_f} - {sp_f[31], sp_f};
	assign diff_mag = diff[32] ? (33'd0 - diff) : diff;
	assign at_f     = diff_mag <= {17'd0, cfg.deadband_steps};

	always_comb begin
		dir_f = dir_q;
		run_f = run_q;
		case (item_s2.opcode)
			OP_PULSE: begin
				if (at_f) begin
					run_f = 1'b0;
				end
			end
			OP_UPDATE: begin
				if (at_f) begin
					run_f = 1'b0;
				end else begin
					dir_f = $signed(pos_f) > $signed(sp_f);
					run_f = 1'b1;
				end
			end
			OP_LOAD: begin
				dir_f = 1'b0;
				run_f = 1'b0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			sp_q    <= '0;
			dir_q   <= 1'b0;
			run_q   <= 1'b0;
			fault_q <= 1'b0;
			prof_q  <= PROF_NONE;
			per_q   <= '0;
		end else if (load_out) begin
			pos_q   <= pos_f;
			sp_q    <= sp_f;
			dir_q   <= dir_f;
			run_q   <= run_f;
			fault_q <= fault_f;
			prof_q  <= prof_f;
			per_q   <= per_f;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			res_q.position_now    <= pos_f;
			res_q.running         <= run_f;
			res_q.direction_level <= ~dir_f ^ cfg.invert_direction;
			res_q.moving_down     <= dir_f;
			res_q.arrived         <= at_f;
			res_q.fault_seen      <= fault_f;
			res_q.period_ticks    <= per_f;
			res_q.profile_now     <= prof_f;
		end
	end

endmodule

/* rtl/stepper_position_step_controller_core.sv */
// Step/direction controller that tracks motor position. Each transfer on in_ch is one
// item (step pulse done, control update or position load) and yields exactly one result
// on out_ch showing the controller state after that item. One item is taken per clock while
// out_ch is not stalled; the 32x32 encoder angle multiply sits between the input register
// and a second register, and the state update writes the result register from the second
// register. A stalled out_ch holds the pipeline and, once all three registers are full,
// in_ch. The state update loops through its own state registers, so consecutive items
// see each other's effects. Configure over APB only while no items are in flight.
module stepper_position_step_controller_core import spsc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	spsc_in_if.sink           in_ch,
	spsc_out_if.source        out_ch
);

	spsc_cfg_t cfg;
	spsc_s2_t  item_s2;
	logic      v1_q, v2_q, ov_q;
	logic      load_s1, load_s2, load_out, take_out;

	spsc_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// each stage moves on when the next one is empty or moving on itself
	assign take_out    = ov_q && out_ch.ready;
	assign load_out    = v2_q && (!ov_q || out_ch.ready);
	assign load_s2     = v1_q && (!v2_q || load_out);
	assign in_ch.ready = !v1_q || load_s2;
	assign load_s1     = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (load_s1) begin
				v1_q <= 1'b1;
			end else if (load_s2) begin
				v1_q <= 1'b0;
			end
			if (load_s2) begin
				v2_q <= 1'b1;
			end else if (load_out) begin
				v2_q <= 1'b0;
			end
			if (load_out) begin
				ov_q <= 1'b1;
			end else if (take_out) begin
				ov_q <= 1'b0;
			end
		end
	end

	spsc_enc_stage u_enc (
		.clk     (clk),
		.load_s1 (load_s1),
		.load_s2 (load_s2),
		.in_data (in_ch.data),
		.cfg     (cfg),
		.item_s2 (item_s2)
	);

	spsc_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.load_out (load_out),
		.item_s2  (item_s2),
		.cfg      (cfg),
		.res_q    (out_ch.data)
	);

	assign out_ch.valid = ov_q;

endmodule
